// ===== rtl/bhw_pkg.sv =====
// Shared constants and types for the bit crusher with Hann window.
`default_nettype none

package bhw_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUSH_FACTOR = 2'd1;

   // Register reset values.
   localparam int FRAME_LENGTH_RESET = 1024;
   localparam logic [CSR_DATA_W-1:0] CRUSH_FACTOR_RESET = 16'd256;

   // Level count: levels = max(2, 65536 / max(256, crush_factor)).
   localparam logic [CSR_DATA_W-1:0] CRUSH_FLOOR = 16'd256;
   localparam logic [16:0] LEVELS_NUM = 17'h10000;
   localparam int LEVELS_W = 9;
   localparam int STEP_REM_W = 8;
   localparam int FILL_REM_W = 10;

   // Step count magnitude never exceeds half of 256 levels.
   localparam int KMAG_W = 8;
   localparam logic [KMAG_W-1:0] KMAG_MAX = 8'd128;

   // Window in Q16, 65536 is one.
   localparam int WIN_W = 17;
   localparam logic [WIN_W-1:0] WIN_ONE = 17'h10000;
   localparam int WIN_ROUND = 32768;

   // Cosine table generation in Q30.
   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// ===== rtl/bhw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bhw_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bhw_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module bhw_div #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output bhw_pkg::div_stat_type stat,
   output logic [NUM_W-1:0]     quo,
   output logic [DEN_W-1:0]     rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   // Bring down the next numerator bit and subtract where it fits.
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      ge = trial >= {1'b0, den_ff};
      rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(NUM_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/bitcrush_hann_window.sv =====
// Top level of the bit crusher with Hann window: sample pipeline and setup sequencer.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata: sample_value, sample_index
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: crushed_sample, result_index
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// The pipeline takes one item per cycle while no setup pass runs and no
// stalled result holds it up. Its depth is set by the window phase divider,
// which settles one quotient bit per stage. After reset and after each
// crush_factor write a setup pass computes the level count and fills the
// step table, and req_tready stays low meanwhile. Reset is synchronous and
// active high. A stalled result holds only the stages behind it that are
// full; empty stages keep filling, so nothing is lost or repeated.

module bitcrush_hann_window #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int INDEX_WIDTH = 16,
   parameter int COS_TABLE_DEPTH = 256,
   localparam int TDATA_W = ((SAMPLE_WIDTH + INDEX_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [TDATA_W-1:0]              req_tdata,  // sample_value, sample_index
   // Result items.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [TDATA_W-1:0]              rsp_tdata,  // crushed_sample, result_index
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bhw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bhw_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int IW = INDEX_WIDTH;
   localparam int PW = $clog2(COS_TABLE_DEPTH);
   localparam int ROM_N = 1 << PW;
   localparam int VAL_W = SW + bhw_pkg::WIN_W;
   localparam int NUM_W = IW + PW;
   localparam int L = PW + 4;
   localparam int DIV_W = (SW + 1 > 17) ? SW + 1 : 17;
   localparam int FQ_W = SW + 8;
   localparam int KDEPTH = 1 << bhw_pkg::KMAG_W;

   localparam logic [SW:0]   Y_ONE = {2'b01, {(SW - 1){1'b0}}};
   localparam logic [SW-1:0] Y_MAX = {1'b0, {(SW - 1){1'b1}}};
   localparam logic [FQ_W-1:0] Q_ONE = FQ_W'(Y_ONE);
   localparam logic [VAL_W-1:0] K_HALF = VAL_W'(Y_ONE);

   // Setup sequencer codes.
   localparam int SEQ_W = 3;
   localparam logic [SEQ_W-1:0] SEQ_IDLE    = 3'd0;
   localparam logic [SEQ_W-1:0] SEQ_LVL_GO  = 3'd1;
   localparam logic [SEQ_W-1:0] SEQ_LVL     = 3'd2;
   localparam logic [SEQ_W-1:0] SEQ_STEP_GO = 3'd3;
   localparam logic [SEQ_W-1:0] SEQ_STEP    = 3'd4;
   localparam logic [SEQ_W-1:0] SEQ_FILL    = 3'd5;

   // One pipeline stage. The val field holds, by stage, the scaled sample
   // magnitude, the quantized magnitude, the windowed product, and the result.
   typedef struct packed {
      logic                          neg;
      logic [VAL_W-1:0]              val;
      logic [IW-1:0]                 idx;
      logic [IW-1:0]                 rem;
      logic [PW-1:0]                 lo;
      logic [PW-1:0]                 quo;
      logic [bhw_pkg::WIN_W-1:0]     win;
   } stage_type;

   // Configuration registers.
   logic [IW-1:0]                  frame_length_ff;
   logic [bhw_pkg::CSR_DATA_W-1:0] crush_factor_ff;
   logic                           csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= IW'(bhw_pkg::FRAME_LENGTH_RESET);
         crush_factor_ff <= bhw_pkg::CRUSH_FACTOR_RESET;
      end else if (csr_wr) begin
         if (csr_index == bhw_pkg::CSR_FRAME_LENGTH) begin
            frame_length_ff <= IW'(csr_data);
         end
         if (csr_index == bhw_pkg::CSR_CRUSH_FACTOR) begin
            crush_factor_ff <= csr_data;
         end
      end
   end

   // Setup: the level count, then the quotient and remainder of 2^SW / levels,
   // then the step table q(k) = round(k * 2^SW / levels), clamped to one,
   // built incrementally one entry per cycle.
   logic [SEQ_W-1:0]                 seq_ff, seq_in;
   logic [bhw_pkg::LEVELS_W-1:0]     levels_ff, levels_in;
   logic [SW-1:0]                    step_q_ff, step_q_in;
   logic [bhw_pkg::STEP_REM_W-1:0]   step_r_ff, step_r_in;
   logic [bhw_pkg::KMAG_W-1:0]       fill_k_ff, fill_k_in;
   logic [FQ_W-1:0]                  fill_quo_ff, fill_quo_in;
   logic [bhw_pkg::FILL_REM_W-1:0]   fill_rem_ff, fill_rem_in;
   logic [bhw_pkg::FILL_REM_W-1:0]   rem_sum;
   logic                             wrap;
   logic                             busy;

   logic                             div_start;
   logic [DIV_W-1:0]                 div_num;
   logic [15:0]                      div_den;
   logic [15:0]                      crush_floor;
   bhw_pkg::div_stat_type            div_stat;
   logic [DIV_W-1:0]                 div_quo;
   logic [15:0]                      div_rem;

   assign crush_floor = (crush_factor_ff < bhw_pkg::CRUSH_FLOOR) ?
                        bhw_pkg::CRUSH_FLOOR : crush_factor_ff;
   assign div_start = (seq_ff == SEQ_LVL_GO) || (seq_ff == SEQ_STEP_GO);
   assign div_num = (seq_ff == SEQ_LVL_GO) ? DIV_W'(bhw_pkg::LEVELS_NUM) :
                    (DIV_W'(1) << SW);
   assign div_den = (seq_ff == SEQ_LVL_GO) ? crush_floor : 16'(levels_ff);

   bhw_div #(
      .NUM_W (DIV_W),
      .DEN_W (16)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      seq_in = seq_ff;
      levels_in = levels_ff;
      step_q_in = step_q_ff;
      step_r_in = step_r_ff;
      fill_k_in = fill_k_ff;
      fill_quo_in = fill_quo_ff;
      fill_rem_in = fill_rem_ff;
      rem_sum = fill_rem_ff + bhw_pkg::FILL_REM_W'(step_r_ff);
      wrap = rem_sum >= bhw_pkg::FILL_REM_W'(levels_ff);
      unique case (seq_ff)
         SEQ_IDLE: begin
         end
         SEQ_LVL_GO: begin
            seq_in = SEQ_LVL;
         end
         SEQ_LVL: begin
            if (div_stat.done) begin
               seq_in = SEQ_STEP_GO;
               levels_in = (div_quo < DIV_W'(2)) ? bhw_pkg::LEVELS_W'(2) :
                           div_quo[bhw_pkg::LEVELS_W-1:0];
            end
         end
         SEQ_STEP_GO: begin
            seq_in = SEQ_STEP;
         end
         SEQ_STEP: begin
            if (div_stat.done) begin
               seq_in = SEQ_FILL;
               step_q_in = div_quo[SW-1:0];
               step_r_in = div_rem[bhw_pkg::STEP_REM_W-1:0];
               fill_k_in = '0;
               fill_quo_in = '0;
               fill_rem_in = bhw_pkg::FILL_REM_W'(levels_ff >> 1);
            end
         end
         SEQ_FILL: begin
            fill_k_in = fill_k_ff + bhw_pkg::KMAG_W'(1);
            fill_rem_in = wrap ? rem_sum - bhw_pkg::FILL_REM_W'(levels_ff) : rem_sum;
            fill_quo_in = fill_quo_ff + FQ_W'(step_q_ff) + FQ_W'(wrap);
            if (fill_k_ff == bhw_pkg::KMAG_MAX) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
      // A new crush factor restarts the whole setup pass.
      if (csr_wr && csr_index == bhw_pkg::CSR_CRUSH_FACTOR) begin
         seq_in = SEQ_LVL_GO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_LVL_GO;
      end else begin
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      step_q_ff <= step_q_in;
      step_r_ff <= step_r_in;
      fill_k_ff <= fill_k_in;
      fill_quo_ff <= fill_quo_in;
      fill_rem_ff <= fill_rem_in;
   end

   assign busy = (seq_ff != SEQ_IDLE);

   // Step table: quantized magnitude for each step count magnitude.
   logic                         ram_wr_en;
   logic [SW-1:0]                ram_wr_data;
   logic [bhw_pkg::KMAG_W-1:0]   ram_rd_addr;
   logic [SW-1:0]                ram_rd_data;

   assign ram_wr_en = (seq_ff == SEQ_FILL);
   assign ram_wr_data = (fill_quo_ff > Q_ONE) ? SW'(Y_ONE) : fill_quo_ff[SW-1:0];

   // Cosine window table, one entry per phase, as w = 32768 - cos in Q16.
   // Each entry folds its angle into the first quadrant and sums a Taylor
   // series in Q30. Phases past the table depth repeat the last entry.
   logic [bhw_pkg::WIN_W-1:0] win_rom [ROM_N];

   for (genvar g = 0; g < ROM_N; g++) begin : g_win
      localparam longint unsigned D = COS_TABLE_DEPTH;
      localparam longint unsigned P = (g < COS_TABLE_DEPTH) ? g : COS_TABLE_DEPTH - 1;
      localparam longint unsigned A = 4 * P;
      localparam longint unsigned U = (A <= D) ? A : (A <= 2 * D) ? 2 * D - A :
                                      (A <= 3 * D) ? A - 2 * D : 4 * D - A;
      localparam bit NEG = (A > D) && (A <= 3 * D);
      localparam longint unsigned X = (bhw_pkg::PI_HALF_Q30 * U) / COS_TABLE_DEPTH;
      localparam longint unsigned X2 = (X * X) >> 30;
      localparam longint unsigned T1 = bhw_pkg::Q30_ONE -
                                       ((X2 * bhw_pkg::Q30_ONE) >> 30) / 90;
      localparam longint unsigned T2 = bhw_pkg::Q30_ONE - ((X2 * T1) >> 30) / 56;
      localparam longint unsigned T3 = bhw_pkg::Q30_ONE - ((X2 * T2) >> 30) / 30;
      localparam longint unsigned T4 = bhw_pkg::Q30_ONE - ((X2 * T3) >> 30) / 12;
      localparam longint unsigned H = (X2 * T4) >> 31;
      localparam longint unsigned C30 = (H >= bhw_pkg::Q30_ONE) ? 0 : bhw_pkg::Q30_ONE - H;
      localparam longint unsigned C15R = (C30 + 16384) >> 15;
      localparam longint unsigned C15 = (C15R > 32768) ? 32768 : C15R;
      localparam longint unsigned W = NEG ? 32768 + C15 : 32768 - C15;
      assign win_rom[g] = bhw_pkg::WIN_W'(W);
   end

   // Pipeline. A stage loads when it is empty or when the stage after it
   // loads, so bubbles close up behind a stalled result.
   stage_type stg_ff [L];
   stage_type stg_in [L];
   logic [L-1:0] v_ff;
   logic [L-1:0] en;

   assign en[L-1] = !v_ff[L-1] || rsp_tready;
   for (genvar k = 0; k < L - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   assign req_tready = en[0] && !busy;

   // Stage 0: sign and magnitude, magnitude times the level count, and the
   // phase numerator index * depth split into its top and its low PW bits.
   logic [SW-1:0]    in_s;
   logic [IW-1:0]    in_idx;
   logic [SW-1:0]    in_mag;
   logic [NUM_W-1:0] in_num;
   logic             in_keep;

   always_comb begin
      in_s = req_tdata[SW-1:0];
      in_idx = req_tdata[SW+IW-1:SW];
      in_mag = in_s[SW-1] ? (~in_s + SW'(1)) : in_s;
      in_num = NUM_W'(in_idx) * NUM_W'(COS_TABLE_DEPTH);
      in_keep = in_idx < frame_length_ff;
      stg_in[0].neg = in_s[SW-1];
      stg_in[0].val = VAL_W'(in_mag) * VAL_W'(levels_ff);
      stg_in[0].idx = in_idx;
      stg_in[0].rem = in_num[NUM_W-1:PW];
      stg_in[0].lo = in_num[PW-1:0];
      stg_in[0].quo = '0;
      stg_in[0].win = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         // Items outside the frame are dropped here.
         v_ff[0] <= req_tvalid && req_tready && in_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         stg_ff[0] <= stg_in[0];
      end
   end

   // Step count magnitude k = round(|s| * levels / 2^SW) addresses the table;
   // its read data lands alongside stage 1.
   assign ram_rd_addr = bhw_pkg::KMAG_W'((stg_ff[0].val + K_HALF) >> SW);

   bhw_ram #(
      .DATA_W (SW),
      .DEPTH  (KDEPTH)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_k_ff),
      .wr_data (ram_wr_data),
      .rd_en   (en[1]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Stages 1 to PW each settle one phase quotient bit. Stage 2 picks up the
   // quantized magnitude, stage PW+1 looks up the window, stage PW+2
   // multiplies, and the last stage rounds, restores the sign and saturates.
   for (genvar k = 1; k < L; k++) begin : g_stage
      always_comb begin
         stage_type     prev;
         logic [IW:0]   trial;
         logic          ge;
         logic [VAL_W-1:0] rnd;
         logic [SW:0]   ymag;
         logic [SW-1:0] yv;
         prev = stg_ff[k-1];
         stg_in[k] = prev;
         trial = {prev.rem, prev.lo[PW-1]};
         ge = trial >= {1'b0, frame_length_ff};
         rnd = prev.val + VAL_W'(bhw_pkg::WIN_ROUND);
         ymag = rnd[VAL_W-1:16];
         if (prev.neg) begin
            yv = SW'(~ymag + (SW + 1)'(1));
         end else if (ymag >= Y_ONE) begin
            yv = Y_MAX;
         end else begin
            yv = ymag[SW-1:0];
         end
         if (k <= PW) begin
            stg_in[k].rem = ge ? IW'(trial - {1'b0, frame_length_ff}) : trial[IW-1:0];
            stg_in[k].lo = prev.lo << 1;
            stg_in[k].quo = {prev.quo[PW-2:0], ge};
         end
         if (k == 2) begin
            stg_in[k].val = VAL_W'(ram_rd_data);
         end
         if (k == PW + 1) begin
            stg_in[k].win = (crush_factor_ff == '0) ? bhw_pkg::WIN_ONE : win_rom[prev.quo];
         end
         if (k == PW + 2) begin
            stg_in[k].val = VAL_W'(prev.val[SW-1:0]) * VAL_W'(prev.win);
         end
         if (k == PW + 3) begin
            stg_in[k].val = VAL_W'(yv);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign rsp_tvalid = v_ff[L-1];
   assign rsp_tdata = TDATA_W'({stg_ff[L-1].idx, stg_ff[L-1].val[SW-1:0]});

   // While setup runs, a free input stage must stay empty.
   a_no_entry_in_setup: assert property (
      @(posedge clock) disable iff (reset)
      (busy && en[0]) |=> !v_ff[0]
   ) else $error("item entered the pipeline during setup");

   // The divider is finished before the table fill starts.
   a_div_idle_in_fill: assert property (
      @(posedge clock) disable iff (reset)
      (seq_ff == SEQ_FILL || seq_ff == SEQ_IDLE) |-> !div_stat.busy
   ) else $error("divider still running during fill or idle");

   // A result from a non-negative sample never wraps negative.
   a_pos_saturates: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && !stg_ff[L-1].neg) |-> !rsp_tdata[SW-1]
   ) else $error("positive result wrapped past full scale");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the bit crusher with Hann window.
`default_nettype none

module tb;

   // Clock period, the wait after the last result before a register write or
   // the end of the run, and the fixed limit of the whole run.
   localparam int CLK_PERIOD = 12;
   localparam int SETTLE_CYCLES = 20;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_GAP = 17;
   localparam int MAX_REPORTS = 10;

   // Register indexes that the block does not decode; writes to them are
   // dropped.
   localparam logic [bhw_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [bhw_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // Fixed-point constants of the window cosine, in Q30.
   localparam longint unsigned COS_ONE_Q30 = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned COS_DEPTH = 64'd256;

   // One expected result item.
   typedef struct packed {
      logic [15:0] crushed;
      logic [15:0] position;
   } crushed_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // sample_value [15:0], sample_index [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // crushed_sample [15:0], result_index [31:16]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [bhw_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bhw_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Our own copy of the two registers, updated when a write is accepted.
   logic [15:0] cfg_frame_len = 16'(bhw_pkg::FRAME_LENGTH_RESET);
   logic [15:0] cfg_crush = bhw_pkg::CRUSH_FACTOR_RESET;

   crushed_item_type pending_results[$];
   int unsigned      mismatch_count = 0;

   // When set, both sides run without idling; it is redrawn during the random
   // phases so that stretches of full rate alternate with gaps and stalls.
   bit steady_flow = 1'b0;

   bitcrush_hann_window dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Division rounded to the nearest integer, halves away from zero; the
   // divisor is always positive.
   function automatic longint div_round(input longint num, input longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   // Cosine of 2*pi*phase/256 in Q1.15. The phase is folded into the first
   // quadrant, the angle is built in Q30 and the cosine comes from a nested
   // Taylor series through x^10, floored at zero and rounded to Q15.
   function automatic longint window_cos_q15(input longint unsigned phase);
      longint unsigned quad, fold, x, x2, t, h, c30, c15;
      bit              negate;
      quad = 4 * phase;
      if (quad <= COS_DEPTH) begin
         fold = quad;
         negate = 1'b0;
      end else if (quad <= 2 * COS_DEPTH) begin
         fold = 2 * COS_DEPTH - quad;
         negate = 1'b1;
      end else if (quad <= 3 * COS_DEPTH) begin
         fold = quad - 2 * COS_DEPTH;
         negate = 1'b1;
      end else begin
         fold = 4 * COS_DEPTH - quad;
         negate = 1'b0;
      end
      x = (HALF_PI_Q30 * fold) / COS_DEPTH;
      x2 = (x * x) >> 30;
      t = COS_ONE_Q30;
      t = COS_ONE_Q30 - ((x2 * t) >> 30) / 64'd90;
      t = COS_ONE_Q30 - ((x2 * t) >> 30) / 64'd56;
      t = COS_ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
      t = COS_ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
      h = (x2 * t) >> 31;
      c30 = (h >= COS_ONE_Q30) ? 64'd0 : COS_ONE_Q30 - h;
      c15 = (c30 + 64'd16384) >> 15;
      if (c15 > 64'd32768) c15 = 64'd32768;
      return negate ? -longint'(c15) : longint'(c15);
   endfunction

   // Works out the result of one item under the current registers. Returns 0
   // when the index lies outside the frame and no result is due.
   function automatic bit crush_and_window(input logic signed [15:0] smp,
                                           input logic [15:0] idx,
                                           output logic [15:0] crushed);
      longint          s, levels, steps, quant, win, y;
      longint unsigned floor_factor, phase;
      crushed = '0;
      if (idx >= cfg_frame_len) return 1'b0;
      s = smp;
      floor_factor = (cfg_crush < 16'd256) ? 64'd256 : 64'(cfg_crush);
      levels = longint'(64'd65536 / floor_factor);
      if (levels < 2) levels = 2;
      // Quantize to the nearest of the levels, then back to Q1.15 and clamp.
      steps = div_round(s * levels, 65536);
      quant = div_round(steps * 65536, levels);
      if (quant > 32768) quant = 32768;
      if (quant < -32768) quant = -32768;
      // A zero crush factor bypasses the window entirely.
      win = 65536;
      if (cfg_crush != 16'd0) begin
         phase = (64'(idx) * COS_DEPTH) / 64'(cfg_frame_len);
         if (phase >= COS_DEPTH) phase = COS_DEPTH - 1;
         win = 32768 - window_cos_q15(phase);
      end
      // Exactly plus one cannot be coded and saturates to the top code.
      y = div_round(quant * win, 65536);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      crushed = y[15:0];
      return 1'b1;
   endfunction

   // Counts a failure and reports only the first few in full.
   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%t tb: %s", $realtime, what);
   endtask

   // Offers one item after a random gap, or none while the flow is steady, and
   // records the result it should cause once the block has taken it. The valid
   // stays high after the handshake so back-to-back items need no extra edge.
   task automatic send_sample(input logic [15:0] smp, input logic [15:0] idx);
      int unsigned      gap;
      logic [15:0]      crushed;
      crushed_item_type due;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {idx, smp};
      do @(posedge clock); while (!req_tready);
      if (crush_and_window(smp, idx, crushed)) begin
         due.crushed = crushed;
         due.position = idx;
         pending_results.push_back(due);
      end
   endtask

   // Stops offering items, waits for every outstanding result, then lets the
   // settle time pass. Items outside the frame are dropped on entry and leave
   // no result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register. Only called when no result is outstanding.
   task automatic write_csr(input logic [bhw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bhw_pkg::CSR_FRAME_LENGTH: cfg_frame_len = value;
         bhw_pkg::CSR_CRUSH_FACTOR: cfg_crush = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] frame_len, input logic [15:0] factor);
      write_csr(bhw_pkg::CSR_FRAME_LENGTH, frame_len);
      write_csr(bhw_pkg::CSR_CRUSH_FACTOR, factor);
   endtask

   // Reset registers: a 1024-sample frame with 256 levels and the window on.
   // Covers the sample extremes, the window at both frame edges and at its
   // peak, and the first index past the frame and the largest index.
   task automatic test_reset_config();
      send_sample(16'h8000, 16'd0);
      send_sample(16'h7FFF, 16'd512);
      send_sample(16'h0000, 16'd1023);
      send_sample(16'h0001, 16'd256);
      send_sample(16'hFFFF, 16'd768);
      send_sample(16'h4000, 16'd100);
      send_sample(16'h7FFF, 16'd1024);
      send_sample(16'h8000, 16'hFFFF);
      drain_results();
   endtask

   // Zero crush factor: no window and 256 levels, so a full-scale positive
   // sample rounds up to plus one and has to saturate.
   task automatic test_unwindowed_saturation();
      write_csr(bhw_pkg::CSR_CRUSH_FACTOR, 16'd0);
      send_sample(16'h7FFF, 16'd0);
      send_sample(16'h8000, 16'd0);
      send_sample(16'h3FFF, 16'd512);
      send_sample(16'h7FFF, 16'hFFFF);
      drain_results();
   endtask

   // The coarsest settings leave two levels; at the window peak a large
   // positive sample reaches plus one again.
   task automatic test_coarse_levels();
      write_csr(bhw_pkg::CSR_CRUSH_FACTOR, 16'h8000);
      send_sample(16'h7FFF, 16'd512);
      send_sample(16'hC000, 16'd511);
      drain_results();
      write_csr(bhw_pkg::CSR_CRUSH_FACTOR, 16'hFFFF);
      send_sample(16'h4000, 16'd513);
      send_sample(16'h8001, 16'd1);
      drain_results();
   endtask

   // A zero frame length puts every index outside the frame.
   task automatic test_empty_frame();
      write_csr(bhw_pkg::CSR_FRAME_LENGTH, 16'd0);
      send_sample(16'h1234, 16'd0);
      send_sample(16'h7FFF, 16'hFFFF);
      send_sample(16'h8000, 16'd1);
      drain_results();
   endtask

   // Writes to undecoded indexes must leave both registers as they were.
   task automatic test_spare_registers();
      set_config(16'd16, 16'd256);
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'h0000);
      send_sample(16'h5555, 16'd15);
      send_sample(16'hAAAA, 16'd8);
      send_sample(16'h5555, 16'd16);
      drain_results();
   endtask

   // Random items under a run of register settings, the extremes first and
   // random ones after. Most indexes fall inside the frame; the rest probe
   // the region past it.
   task automatic test_random_settings();
      logic [15:0] frame_set[8] = '{16'd1024, 16'd1, 16'd2, 16'd255,
                                    16'd256, 16'd257, 16'hFFFF, 16'd4096};
      logic [15:0] factor_set[8] = '{16'd256, 16'd0, 16'hFFFF, 16'd1,
                                     16'd255, 16'd257, 16'h8000, 16'h0200};
      logic [15:0] corners[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      logic [15:0] frame_len, factor, smp, idx;
      for (int setting = 0; setting < 12; setting++) begin
         if (setting < 8) begin
            frame_len = frame_set[setting];
            factor = factor_set[setting];
         end else begin
            frame_len = 16'($urandom_range(1, 65535));
            factor = 16'($urandom());
         end
         set_config(frame_len, factor);
         for (int n = 0; n < 100; n++) begin
            if (n % 32 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) smp = corners[$urandom_range(0, 4)];
            else smp = 16'($urandom());
            if ($urandom_range(0, 99) < 12) idx = 16'($urandom_range(frame_len, 65535));
            else idx = 16'($urandom_range(0, frame_len - 1));
            send_sample(smp, idx);
            // Halfway through the first setting the sender holds off until
            // every result so far has come back.
            if (setting == 0 && n == 50) begin
               req_tvalid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
               @(posedge clock);
            end
         end
         steady_flow = 1'b0;
         drain_results();
      end
   endtask

   // Result side: stalls a random number of cycles before each item, or not
   // at all while the flow is steady.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Every accepted result is checked against the oldest outstanding one.
   always @(posedge clock) begin : check_results
      crushed_item_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result crushed=%h index=%0d",
                                    rsp_tdata[15:0], rsp_tdata[31:16]));
         end else begin
            due = pending_results.pop_front();
            if (rsp_tdata[15:0] !== due.crushed)
               flag_mismatch($sformatf("crushed_sample index %0d: expected %h, got %h",
                                       due.position, due.crushed, rsp_tdata[15:0]));
            if (rsp_tdata[31:16] !== due.position)
               flag_mismatch($sformatf("result_index: expected %0d, got %0d",
                                       due.position, rsp_tdata[31:16]));
         end
      end
   end

   // Main sequence: reset once, the directed cases, then the random settings.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_unwindowed_saturation();
      test_coarse_levels();
      test_empty_frame();
      test_spare_registers();
      test_random_settings();
      drain_results();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Hard limit on the run in case a handshake never completes.
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
